/* design/multiwave_phase_oscillator_assert.svh */
// Assertion macros shared by the multiwave phase oscillator RTL.
`ifndef MULTIWAVE_PHASE_OSCILLATOR_ASSERT_SVH
`define MULTIWAVE_PHASE_OSCILLATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define MPO_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define MPO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MPO_ASSERT_SAME(label, clk, rst, ante, cons, msg)

`define MPO_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* design/mpo_pkg.sv */
// Shared types, constants and the sine table generator of the phase oscillator.
package mpo_pkg;

   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int STEP_BITS      = 32;
   localparam int AMP_BITS       = 15;
   localparam int AMP_FRAC_BITS  = 15;
   localparam int MULT_BITS      = 5;

   localparam logic [AMP_BITS-1:0]  AMP_RESET  = 15'd32767;
   localparam logic [MULT_BITS-1:0] MULT_RESET = 5'd1;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;
   localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210};

   typedef enum logic [1:0] {
      WAVE_SINE  = 2'd0,
      WAVE_SAW   = 2'd1,
      WAVE_TRI   = 2'd2,
      WAVE_PULSE = 2'd3
   } wave_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WAVEFORM   = 2'd0,
      CSR_PHASE_STEP = 2'd1,
      CSR_AMPLITUDE  = 2'd2,
      CSR_MULTIPLIER = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOOK   = 4'b0010,
      ST_SCALE  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic capture;
      logic look;
      logic scale;
      logic finish;
   } stage_ctrl_type;

   // Quarter-wave sine entry: a fixed-point Taylor series with truncating steps.
   function automatic logic [63:0] sine_entry(input int unsigned k,
                                              input int unsigned table_bits,
                                              input int unsigned frac_w);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      x    = (PI_Q30 * (64'(2 * k) + 64'd1)) >> (table_bits + 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n];
         if ((n % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      return ((64'(sum) << frac_w) + 64'd536870912) >> 30;
   endfunction

endpackage

/* design/mpo_sine_rom.sv */
// Quarter-wave sine table held as a synchronous read-only memory.
module mpo_sine_rom
   import mpo_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [SINE_TABLE_BITS-1:0] rd_addr,
   output logic [SAMPLE_BITS-1:0]     rd_data_ff
);

   localparam int TABLE_DEPTH = 1 << SINE_TABLE_BITS;

   typedef logic [SAMPLE_BITS-1:0] rom_type [TABLE_DEPTH];

   function automatic rom_type build_rom();
      rom_type t;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         t[k] = SAMPLE_BITS'(sine_entry(k, SINE_TABLE_BITS, SAMPLE_BITS - 1));
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= SINE_ROM[rd_addr];
      end
   end

endmodule

/* design/mpo_wave.sv */
// Phase accumulator, harmonic multiply and waveform shaping.
module mpo_wave
   import mpo_pkg::*;
#(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  stage_ctrl_type             ctrl,
   input  wave_type                   waveform,
   input  logic [STEP_BITS-1:0]       phase_step,
   input  logic [MULT_BITS-1:0]       multiplier,
   output logic signed [SAMPLE_BITS:0] wave_value
);

   localparam logic signed [SAMPLE_BITS:0] FULL_SCALE =
      (SAMPLE_BITS + 1)'(1) << (SAMPLE_BITS - 1);

   logic [PHASE_BITS-1:0]          phase_ff;
   logic [PHASE_BITS-1:0]          phase_in;
   logic [PHASE_BITS-1:0]          harm_ff;
   logic [PHASE_BITS+MULT_BITS-1:0] harm_full;
   logic [SAMPLE_BITS-1:0]         coarse;
   logic signed [SAMPLE_BITS:0]    saw;
   logic signed [SAMPLE_BITS:0]    abs_saw;
   logic signed [SAMPLE_BITS:0]    tri_wave;
   logic signed [SAMPLE_BITS:0]    shape_in;
   logic signed [SAMPLE_BITS:0]    shape_ff;
   logic                           is_sine_ff;
   logic                           negate_ff;
   logic [SINE_TABLE_BITS-1:0]     table_idx;
   logic [SINE_TABLE_BITS-1:0]     rom_addr;
   logic [SAMPLE_BITS-1:0]         rom_data;
   logic signed [SAMPLE_BITS:0]    sine_mag;

   assign phase_in  = phase_ff + PHASE_BITS'(phase_step);
   assign harm_full = (PHASE_BITS + MULT_BITS)'(phase_ff) *
                      (PHASE_BITS + MULT_BITS)'(multiplier);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (ctrl.capture) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         harm_ff <= harm_full[PHASE_BITS-1:0];
      end
   end

   generate
      if (PHASE_BITS >= SAMPLE_BITS) begin : g_coarse_cut
         assign coarse = harm_ff[PHASE_BITS-1 -: SAMPLE_BITS];
      end else begin : g_coarse_pad
         assign coarse = {harm_ff, (SAMPLE_BITS - PHASE_BITS)'(0)};
      end
   endgenerate

   assign saw      = signed'({1'b0, coarse}) - FULL_SCALE;
   assign abs_saw  = saw[SAMPLE_BITS] ? -saw : saw;
   assign tri_wave = (abs_saw <<< 1) - FULL_SCALE;

   always_comb begin
      case (waveform)
         WAVE_SAW:   shape_in = saw;
         WAVE_TRI:   shape_in = tri_wave;
         WAVE_PULSE: begin
            shape_in = ((harm_ff != '0) && !harm_ff[PHASE_BITS-1]) ? FULL_SCALE : -FULL_SCALE;
         end
         default:    shape_in = '0;
      endcase
   end

   assign table_idx = harm_ff[PHASE_BITS-3 -: SINE_TABLE_BITS];
   assign rom_addr  = harm_ff[PHASE_BITS-2] ? ~table_idx : table_idx;

   mpo_sine_rom #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_sine_rom (
      .clock      (clock),
      .rd_en      (ctrl.look),
      .rd_addr    (rom_addr),
      .rd_data_ff (rom_data)
   );

   always_ff @(posedge clock) begin
      if (ctrl.look) begin
         shape_ff   <= shape_in;
         is_sine_ff <= (waveform == WAVE_SINE);
         negate_ff  <= harm_ff[PHASE_BITS-1];
      end
   end

   assign sine_mag   = signed'({1'b0, rom_data});
   assign wave_value = is_sine_ff ? (negate_ff ? -sine_mag : sine_mag) : shape_ff;

endmodule

/* design/mpo_scale.sv */
// Amplitude multiply, rounding half away from zero and output saturation.
module mpo_scale
   import mpo_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  stage_ctrl_type                ctrl,
   input  logic signed [SAMPLE_BITS:0]   wave_value,
   input  logic [AMP_BITS-1:0]           amplitude,
   output logic signed [SAMPLE_BITS-1:0] sample_ff
);

   localparam int PROD_BITS = SAMPLE_BITS + AMP_BITS + 2;
   localparam int RND_BITS  = PROD_BITS - AMP_FRAC_BITS;

   localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (AMP_FRAC_BITS - 1);
   localparam logic [RND_BITS-1:0]  POS_LIMIT  = (RND_BITS'(1) << (SAMPLE_BITS - 1)) - 1'b1;
   localparam logic [RND_BITS-1:0]  NEG_LIMIT  = RND_BITS'(1) << (SAMPLE_BITS - 1);

   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [PROD_BITS-1:0]   prod_in;
   logic                          neg;
   logic [PROD_BITS-1:0]          mag;
   logic [PROD_BITS-1:0]          mag_rnd;
   logic [RND_BITS-1:0]           rounded;
   logic [RND_BITS-1:0]           limited;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   assign prod_in = PROD_BITS'(wave_value) * PROD_BITS'(signed'({1'b0, amplitude}));

   always_ff @(posedge clock) begin
      if (ctrl.scale) begin
         prod_ff <= prod_in;
      end
   end

   assign neg     = prod_ff[PROD_BITS-1];
   assign mag     = neg ? PROD_BITS'(-prod_ff) : PROD_BITS'(prod_ff);
   assign mag_rnd = mag + ROUND_HALF;
   assign rounded = mag_rnd[PROD_BITS-1:AMP_FRAC_BITS];

   always_comb begin
      if (neg) begin
         limited   = (rounded > NEG_LIMIT) ? NEG_LIMIT : rounded;
         sample_in = -signed'(limited[SAMPLE_BITS-1:0]);
      end else begin
         limited   = (rounded > POS_LIMIT) ? POS_LIMIT : rounded;
         sample_in = signed'(limited[SAMPLE_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         sample_ff <= sample_in;
      end
   end

endmodule

/* design/multiwave_phase_oscillator.sv */
// Top level of the multiwave phase oscillator: registers, sequencing and handshakes.
//
// Usage: software writes the waveform, phase step, amplitude and harmonic
// multiplier through the csr_ write port while the block is idle. Each word on
// the req_ channel with req_sample_request set asks for one sample; a word
// with the bit clear is taken and ignored, and the phase holds.
// Each requested sample leaves on the rsp_ channel as one signed word.
// A request passes through the harmonic multiply, the sine table read,
// the amplitude multiply and the rounding stage one after the other, so
// req_stall stays high from an accepted request until its rounding stage
// completes, and no new request is taken before then. The output register
// holds the finished word, so a stalled receiver does not block the next
// request; the block only waits in its last stage while an earlier result
// is still held.
// Reset clears the phase, sets sine, zero step, full amplitude and a
// multiplier of one, and drops rsp_valid.
module multiwave_phase_oscillator
   import mpo_pkg::*;
#(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_sample_request,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

`include "multiwave_phase_oscillator_assert.svh"

   state_type              state_ff;
   state_type              state_in;
   stage_ctrl_type         ctrl;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   wave_type               waveform_ff;
   logic [STEP_BITS-1:0]   phase_step_ff;
   logic [AMP_BITS-1:0]    amplitude_ff;
   logic [MULT_BITS-1:0]   multiplier_ff;
   logic signed [SAMPLE_BITS:0] wave_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff   <= WAVE_SINE;
         phase_step_ff <= '0;
         amplitude_ff  <= AMP_RESET;
         multiplier_ff <= MULT_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_WAVEFORM:   waveform_ff   <= wave_type'(csr_wdata[1:0]);
            CSR_PHASE_STEP: phase_step_ff <= csr_wdata[STEP_BITS-1:0];
            CSR_AMPLITUDE:  amplitude_ff  <= csr_wdata[AMP_BITS-1:0];
            CSR_MULTIPLIER: multiplier_ff <= csr_wdata[MULT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign ctrl.capture = (state_ff == ST_IDLE) && req_valid && req_sample_request;
   assign ctrl.look    = (state_ff == ST_LOOK);
   assign ctrl.scale   = (state_ff == ST_SCALE);
   assign ctrl.finish  = (state_ff == ST_FINISH) && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      unique case (state_ff)
         ST_IDLE:   state_in = ctrl.capture ? ST_LOOK : ST_IDLE;
         ST_LOOK:   state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_FINISH;
         ST_FINISH: state_in = ctrl.finish ? ST_IDLE : ST_FINISH;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = ctrl.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   mpo_wave #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_wave (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .waveform   (waveform_ff),
      .phase_step (phase_step_ff),
      .multiplier (multiplier_ff),
      .wave_value (wave_value)
   );

   mpo_scale #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_scale (
      .clock      (clock),
      .ctrl       (ctrl),
      .wave_value (wave_value),
      .amplitude  (amplitude_ff),
      .sample_ff  (rsp_sample)
   );

   assign rsp_valid = rsp_valid_ff;

   `MPO_ASSERT_NEXT(a_request_starts_lookup, clock, reset,
      req_valid && !req_stall && req_sample_request, state_ff == ST_LOOK,
      "Accepted request did not start the table lookup.")
   `MPO_ASSERT_SAME(a_result_from_finish, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff == ST_FINISH),
      "Result appeared without passing the rounding stage.")
   `MPO_ASSERT_NEXT(a_held_result_blocks_finish, clock, reset,
      state_ff == ST_FINISH && rsp_valid_ff && rsp_stall,
      state_ff == ST_FINISH && $stable(rsp_sample),
      "A held result was overwritten by the next sample.")

endmodule

/* tb/multiwave_phase_oscillator_tb.sv */
// Self-checking testbench of the multiwave phase oscillator with its own sample predictor.
module multiwave_phase_oscillator_tb;
   import mpo_pkg::*;

   localparam int SINE_ENTRIES = 1024;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 250;
   localparam bit [63:0] PI_FIXED = 64'd3373259426;

   typedef bit [63:0] u64_type;
   typedef enum logic {ROW_REG, ROW_WORD} row_kind_type;
   typedef struct {
      row_kind_type kind;
      csr_index_type idx;
      logic [31:0] data;
      logic request;
      bit pinned;
      logic signed [15:0] pinned_sample;
   } plan_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_sample_request;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [15:0] rsp_sample;
   logic csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   int sine_rom [SINE_ENTRIES];
   wave_type wave_cfg;
   logic [31:0] step_cfg;
   logic [14:0] amp_cfg;
   logic [4:0] mult_cfg;
   logic [31:0] phase_acc;

   logic signed [15:0] pending_samples [$];
   logic signed [15:0] want_sample;
   plan_row_type directed_plan [$];
   int errors;
   int cycle_count;
   int send_idle_pct;
   int stall_pct;
   int hold_token;
   int hold_seen;
   int hold_left;

   multiwave_phase_oscillator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample_request(req_sample_request),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample(rsp_sample),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void fill_sine_rom();
      u64_type x;
      u64_type x2;
      u64_type term;
      longint acc;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         x = (PI_FIXED * u64_type'(2 * k + 1)) >> 12;
         x2 = (x * x) >> 30;
         term = x;
         acc = longint'(x);
         for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / u64_type'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         sine_rom[k] = int'(((u64_type'(acc) << 15) + 64'd536870912) >> 30);
      end
   endfunction

   function automatic void store_setting(csr_index_type idx, logic [31:0] data);
      case (idx)
         CSR_WAVEFORM: wave_cfg = wave_type'(data[1:0]);
         CSR_PHASE_STEP: step_cfg = data;
         CSR_AMPLITUDE: amp_cfg = data[14:0];
         CSR_MULTIPLIER: mult_cfg = data[4:0];
      endcase
   endfunction

   // Forms the sample at the current phase and then advances the phase.
   function automatic logic signed [15:0] next_sample();
      logic [31:0] ph;
      logic [15:0] top;
      logic [9:0] idx;
      int wv;
      longint prod;
      longint mag;
      longint r;
      ph = phase_acc * {27'd0, mult_cfg};
      top = ph[31:16];
      case (wave_cfg)
         WAVE_SINE: begin
            idx = ph[29:20];
            if (ph[30]) begin
               idx = ~idx;
            end
            wv = sine_rom[idx];
            if (ph[31]) begin
               wv = -wv;
            end
         end
         WAVE_SAW: wv = int'(top) - 32768;
         WAVE_TRI: begin
            wv = int'(top) - 32768;
            if (wv < 0) begin
               wv = -wv;
            end
            wv = 2 * wv - 32768;
         end
         WAVE_PULSE: wv = (ph != 0 && !ph[31]) ? 32768 : -32768;
      endcase
      prod = longint'(wv) * longint'(amp_cfg);
      mag = (prod < 0) ? -prod : prod;
      mag = (mag + 16384) >> 15;
      r = (prod < 0) ? -mag : mag;
      if (r > 32767) begin
         r = 32767;
      end
      if (r < -32768) begin
         r = -32768;
      end
      phase_acc = phase_acc + step_cfg;
      return r[15:0];
   endfunction

   function automatic void add_reg(csr_index_type idx, logic [31:0] data);
      plan_row_type row;
      row.kind = ROW_REG;
      row.idx = idx;
      row.data = data;
      row.request = 1'b0;
      row.pinned = 1'b0;
      row.pinned_sample = '0;
      directed_plan.push_back(row);
   endfunction

   function automatic void add_word(logic request, bit pinned, logic signed [15:0] value);
      plan_row_type row;
      row.kind = ROW_WORD;
      row.idx = CSR_WAVEFORM;
      row.data = '0;
      row.request = request;
      row.pinned = pinned;
      row.pinned_sample = value;
      directed_plan.push_back(row);
   endfunction

   task automatic wait_drained();
      while (pending_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] data);
      req_valid <= 1'b0;
      wait_drained();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      store_setting(idx, data);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drive_word(logic request, bit pinned, logic signed [15:0] value);
      logic signed [15:0] predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_request <= request;
      do begin
         @(posedge clock);
      end while (req_stall);
      if (request) begin
         predicted = next_sample();
         pending_samples.push_back(pinned ? value : predicted);
      end
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            $error("sample: expected none, actual %0d", rsp_sample);
            errors++;
         end else begin
            want_sample = pending_samples.pop_front();
            if (rsp_sample !== want_sample) begin
               $error("sample: expected %0d, actual %0d", want_sample, rsp_sample);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [31:0] wave_word;
      logic [31:0] step_word;
      logic [31:0] amp_word;
      logic [31:0] mult_word;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_request = 1'b0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      errors = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_token = 0;
      hold_seen = 0;
      hold_left = 0;
      wave_cfg = WAVE_SINE;
      step_cfg = '0;
      amp_cfg = AMP_RESET;
      mult_cfg = MULT_RESET;
      phase_acc = '0;
      fill_sine_rom();

      add_word(1'b1, 1'b0, '0);
      add_word(1'b0, 1'b0, '0);
      add_reg(CSR_WAVEFORM, 32'(WAVE_PULSE));
      add_word(1'b1, 1'b1, -16'sd32767);
      add_reg(CSR_WAVEFORM, 32'(WAVE_SAW));
      add_word(1'b1, 1'b1, -16'sd32767);
      add_reg(CSR_AMPLITUDE, 32'd0);
      add_word(1'b1, 1'b1, 16'sd0);
      add_reg(CSR_AMPLITUDE, 32'h0000_7FFF);
      add_reg(CSR_PHASE_STEP, 32'h4000_0000);
      add_reg(CSR_WAVEFORM, 32'(WAVE_PULSE));
      add_word(1'b1, 1'b1, -16'sd32767);
      add_word(1'b1, 1'b1, 16'sd32767);
      add_word(1'b1, 1'b1, -16'sd32767);
      add_word(1'b1, 1'b1, -16'sd32767);
      add_reg(CSR_WAVEFORM, 32'(WAVE_TRI));
      add_word(1'b1, 1'b1, 16'sd32767);
      add_word(1'b1, 1'b1, 16'sd0);
      add_word(1'b1, 1'b0, '0);
      add_reg(CSR_WAVEFORM, 32'(WAVE_SINE));
      add_reg(CSR_PHASE_STEP, 32'hFFFF_FFFF);
      add_reg(CSR_MULTIPLIER, 32'd0);
      add_word(1'b1, 1'b0, '0);
      add_word(1'b1, 1'b0, '0);
      add_reg(CSR_MULTIPLIER, 32'd16);
      add_word(1'b1, 1'b0, '0);
      add_word(1'b1, 1'b0, '0);
      add_reg(CSR_MULTIPLIER, 32'd31);
      add_word(1'b1, 1'b0, '0);
      add_reg(CSR_WAVEFORM, 32'(WAVE_SAW));
      add_word(1'b1, 1'b0, '0);
      add_word(1'b1, 1'b0, '0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_REG) begin
            write_reg(directed_plan[i].idx, directed_plan[i].data);
         end else begin
            drive_word(directed_plan[i].request, directed_plan[i].pinned,
                       directed_plan[i].pinned_sample);
         end
      end

      for (int ph = 0; ph < 8; ph++) begin
         wave_word = $urandom;
         if (ph < 4) begin
            wave_word[1:0] = ph[1:0];
         end
         step_word = $urandom;
         amp_word = {17'($urandom_range(17'h1FFFF)), 15'($urandom_range(32767))};
         mult_word = $urandom;
         if ($urandom_range(9) == 0) begin
            mult_word[4:0] = 5'($urandom_range(31));
         end else begin
            mult_word[4:0] = 5'($urandom_range(16, 1));
         end
         case (ph)
            0: amp_word[14:0] = 15'h7FFF;
            1: amp_word[14:0] = 15'h0000;
            2: begin
               step_word = 32'hFFFF_FFFF;
               mult_word[4:0] = 5'd16;
            end
            3: step_word = 32'h0000_0000;
            5: mult_word[4:0] = 5'd1;
            default: ;
         endcase
         write_reg(CSR_WAVEFORM, wave_word);
         write_reg(CSR_PHASE_STEP, step_word);
         write_reg(CSR_AMPLITUDE, amp_word);
         write_reg(CSR_MULTIPLIER, mult_word);
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 58;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 58;
            end
            default: begin
               send_idle_pct = 12;
               stall_pct = 12;
            end
         endcase
         if (ph == 4) begin
            hold_token = hold_token + 1;
         end
         repeat (137) drive_word($urandom_range(9) != 0, 1'b0, '0);
      end

      req_valid <= 1'b0;
      wait_drained();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
